// ===== design/sit_pkg.sv =====
// ----------------------------------------------------------------------------
// sit_pkg
// Shared constants and types for the segment intersection test unit.
// ----------------------------------------------------------------------------
package sit_pkg;

	// default coordinate width, legal range 4 to 30
	localparam int COORD_WIDTH_DEF = 16;

	// sign of one orientation determinant
	typedef struct packed {
		logic pos;
		logic zero;
	} orient_t;

endpackage

// ===== design/segment_intersection_test_unit.sv =====
// ----------------------------------------------------------------------------
// segment_intersection_test_unit
// Exact orientation test for two line segments P = (p1, p2), Q = (q1, q2).
//
// Usage:
//   Input channel (pair_valid / pair_ready) carries one beat of eight signed
//   coordinates. Output channel (res_valid / res_ready) carries one beat with
//   intersects and proper_cross. One result beat per input beat, in order.
//   An accepted pair is registered in s1, then s2, s3 and s4; res_valid is
//   the s4 valid bit. Throughput: one pair per cycle unless res_ready stalls.
//   Four register stages:
//     s1  coordinate differences and span compares
//     s2  eight signed cross-product multiplies
//     s3  compare of the product pairs into orientation signs
//     s4  flag combine, output register
//   Every stage has its own valid bit and advances when the next stage is
//   empty or advancing, so bubbles collapse and a stall drops nothing.
//   Reset clears all valid bits; the pipe is empty and ready right away.
//   When the receiver holds res_ready low, results back up stage by stage;
//   pair_ready falls once all four stages hold a beat.
// ----------------------------------------------------------------------------
module segment_intersection_test_unit #(
	parameter int COORD_WIDTH = sit_pkg::COORD_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          pair_valid,
	output logic                          pair_ready,
	input  logic signed [COORD_WIDTH-1:0] p1_x,
	input  logic signed [COORD_WIDTH-1:0] p1_y,
	input  logic signed [COORD_WIDTH-1:0] p2_x,
	input  logic signed [COORD_WIDTH-1:0] p2_y,
	input  logic signed [COORD_WIDTH-1:0] q1_x,
	input  logic signed [COORD_WIDTH-1:0] q1_y,
	input  logic signed [COORD_WIDTH-1:0] q2_x,
	input  logic signed [COORD_WIDTH-1:0] q2_y,
	output logic                          res_valid,
	input  logic                          res_ready,
	output logic                          intersects,
	output logic                          proper_cross
);
	import sit_pkg::*;

	localparam int DW = COORD_WIDTH + 1;
	localparam int PW = 2 * DW;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;
	typedef logic signed [DW-1:0]          diff_t;
	typedef logic signed [PW-1:0]          prod_t;

	function automatic logic in_span(input coord_t lo_end, input coord_t hi_end,
		input coord_t v);
		return ((lo_end <= v) && (v <= hi_end)) || ((lo_end >= v) && (v >= hi_end));
	endfunction

	function automatic diff_t sub(input coord_t a, input coord_t b);
		return diff_t'(a) - diff_t'(b);
	endfunction

	// stage enables
	logic v_s1, v_s2, v_s3, v_s4;
	logic en_s1, en_s2, en_s3, en_s4;

	assign en_s4      = !v_s4 || res_ready;
	assign en_s3      = !v_s3 || en_s4;
	assign en_s2      = !v_s2 || en_s3;
	assign en_s1      = !v_s1 || en_s2;
	assign pair_ready = en_s1;

	// s1: differences, span tests
	diff_t pux_s1, puy_s1, qux_s1, quy_s1;
	diff_t aq1x_s1, aq1y_s1, aq2x_s1, aq2y_s1;
	diff_t bp1x_s1, bp1y_s1, bp2x_s1, bp2y_s1;
	logic [3:0] span_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en_s1) begin
			v_s1 <= pair_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			pux_s1  <= sub(p2_x, p1_x);
			puy_s1  <= sub(p2_y, p1_y);
			qux_s1  <= sub(q2_x, q1_x);
			quy_s1  <= sub(q2_y, q1_y);
			aq1x_s1 <= sub(q1_x, p1_x);
			aq1y_s1 <= sub(q1_y, p1_y);
			aq2x_s1 <= sub(q2_x, p1_x);
			aq2y_s1 <= sub(q2_y, p1_y);
			bp1x_s1 <= sub(p1_x, q1_x);
			bp1y_s1 <= sub(p1_y, q1_y);
			bp2x_s1 <= sub(p2_x, q1_x);
			bp2y_s1 <= sub(p2_y, q1_y);
			// use the y span when the carrier segment is vertical
			span_s1[0] <= (p1_x != p2_x) ? in_span(p1_x, p2_x, q1_x)
				: in_span(p1_y, p2_y, q1_y);
			span_s1[1] <= (p1_x != p2_x) ? in_span(p1_x, p2_x, q2_x)
				: in_span(p1_y, p2_y, q2_y);
			span_s1[2] <= (q1_x != q2_x) ? in_span(q1_x, q2_x, p1_x)
				: in_span(q1_y, q2_y, p1_y);
			span_s1[3] <= (q1_x != q2_x) ? in_span(q1_x, q2_x, p2_x)
				: in_span(q1_y, q2_y, p2_y);
		end
	end

	// s2: cross-product terms
	prod_t l_s2 [4];
	prod_t r_s2 [4];
	logic [3:0] span_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			l_s2[0] <= prod_t'(pux_s1) * prod_t'(aq1y_s1);
			r_s2[0] <= prod_t'(puy_s1) * prod_t'(aq1x_s1);
			l_s2[1] <= prod_t'(pux_s1) * prod_t'(aq2y_s1);
			r_s2[1] <= prod_t'(puy_s1) * prod_t'(aq2x_s1);
			l_s2[2] <= prod_t'(qux_s1) * prod_t'(bp1y_s1);
			r_s2[2] <= prod_t'(quy_s1) * prod_t'(bp1x_s1);
			l_s2[3] <= prod_t'(qux_s1) * prod_t'(bp2y_s1);
			r_s2[3] <= prod_t'(quy_s1) * prod_t'(bp2x_s1);
			span_s2 <= span_s1;
		end
	end

	// s3: orientation signs
	orient_t o_s3 [4];
	logic [3:0] span_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en_s3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			for (int i = 0; i < 4; i++) begin
				o_s3[i].pos  <= l_s2[i] > r_s2[i];
				o_s3[i].zero <= l_s2[i] == r_s2[i];
			end
			span_s3 <= span_s2;
		end
	end

	// s4: combine into result flags
	logic proper_c, touch_c;
	logic intersects_s4, proper_s4;

	always_comb begin
		proper_c = !o_s3[0].zero && !o_s3[1].zero && !o_s3[2].zero && !o_s3[3].zero
			&& (o_s3[0].pos != o_s3[1].pos) && (o_s3[2].pos != o_s3[3].pos);
		touch_c = 1'b0;
		for (int i = 0; i < 4; i++) begin
			touch_c = touch_c || (o_s3[i].zero && span_s3[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en_s4) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s4) begin
			intersects_s4 <= proper_c || touch_c;
			proper_s4     <= proper_c;
		end
	end

	assign res_valid    = v_s4;
	assign intersects   = intersects_s4;
	assign proper_cross = proper_s4;

	// a proper crossing is always an intersection
	a_proper_implies_hit: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (!proper_cross || intersects))
		else $error("proper_cross set without intersects");

	// a taking receiver never back-pressures the input
	a_ready_chain: assert property (@(posedge clk) disable iff (!arst_n)
		res_ready |-> pair_ready)
		else $error("pair_ready low while res_ready high");

	// a blocked stage keeps its beat
	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && !en_s3) |=> v_s2)
		else $error("stage 2 beat lost under stall");

endmodule
